>>> src/gus_pkg.sv
// Shared types, constants and patch functions for the 2x glyph upscaler.
// No dependencies; every other file in src imports this package.
package gus_pkg;

  localparam int DEF_MAX_SRC_WIDTH  = 10;
  localparam int DEF_MAX_SRC_HEIGHT = 7;

  localparam int NROW   = 7;   // row ports on the input channel
  localparam int SRC_W  = 10;  // bits per source row port
  localparam int SRC_IW = 4;   // index width into one source row
  localparam int IDX_W  = 4;   // output row index width
  localparam int OUT_W  = 20;  // output pixel field width

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] index;
    logic             last;
  } row_ctrl_t;

  // Anti-diagonal patch, row k as a column mask (bit n = column offset n).
  function automatic logic [3:0] anti_patch(input logic [1:0] k);
    logic [3:0] m;
    unique case (k)
      2'd0:    m = 4'hC;
      2'd1:    m = 4'hE;
      2'd2:    m = 4'h7;
      default: m = 4'h3;
    endcase
    return m;
  endfunction

  // Main-diagonal patch, same encoding.
  function automatic logic [3:0] diag_patch(input logic [1:0] k);
    logic [3:0] m;
    unique case (k)
      2'd0:    m = 4'h3;
      2'd1:    m = 4'h7;
      2'd2:    m = 4'hE;
      default: m = 4'hC;
    endcase
    return m;
  endfunction

endpackage

>>> src/glyph_upscale_2x_smoothing.sv
// Top level of the 2x glyph upscaler with diagonal smoothing.
// Depends on gus_pkg, gus_seq, gus_lane and gus_merge.
//
// One input transfer carries a whole glyph (width, height, up to seven
// rows, column c of a row at bit width-1-c). The block answers with
// 2*height output transfers, one per output row in order, each row's
// column j at bit j, and last_row set on the final one. A glyph of zero
// height produces nothing. Width is clamped to MAX_SRC_WIDTH and height to
// MAX_SRC_HEIGHT (and to the seven row ports); output columns from 20 up
// are dropped. The glyph is stored on the input transfer, and its first row
// is then loaded into the output register from the store; rows leave one
// per cycle while the consumer keeps up. The output row sequencer is the
// pacing element: it produces one row a cycle unless the output register
// is stalled, and the next glyph is taken in the same cycle that the
// previous glyph's last row moves into the output register, so glyphs run
// back to back with no gap while the consumer keeps up.
// Inside, the sequencer keeps the glyph as a shift line of source rows
// (row above, current row, row below); MAX_SRC_WIDTH column lanes each
// build four output bits from that window (the 2x block plus any smoothing
// patch rows), and the merge stage ORs the lanes into the output register.
module glyph_upscale_2x_smoothing import gus_pkg::*; #(
  parameter int MAX_SRC_WIDTH  = DEF_MAX_SRC_WIDTH,
  parameter int MAX_SRC_HEIGHT = DEF_MAX_SRC_HEIGHT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [3:0]          glyph_width,
  input  logic [2:0]          glyph_height,
  input  logic [SRC_W-1:0]    row0,
  input  logic [SRC_W-1:0]    row1,
  input  logic [SRC_W-1:0]    row2,
  input  logic [SRC_W-1:0]    row3,
  input  logic [SRC_W-1:0]    row4,
  input  logic [SRC_W-1:0]    row5,
  input  logic [SRC_W-1:0]    row6,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [IDX_W-1:0]    out_row_index,
  output logic [OUT_W-1:0]    out_pixels,
  output logic                last_row
);

  logic [NROW-1:0][SRC_W-1:0] rows_in;
  row_ctrl_t                  ctrl;
  logic                       row_ready;
  logic                       phase;
  logic [MAX_SRC_WIDTH-1:0]   up_row, cur_row, dn_row;
  logic [3:0]                 nibbles [MAX_SRC_WIDTH];

  assign rows_in = {row6, row5, row4, row3, row2, row1, row0};

  gus_seq #(
    .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .glyph_width  (glyph_width),
    .glyph_height (glyph_height),
    .rows_in      (rows_in),
    .row_ready    (row_ready),
    .ctrl         (ctrl),
    .phase        (phase),
    .up_row       (up_row),
    .cur_row      (cur_row),
    .dn_row       (dn_row)
  );

  // One lane per source column; the rightmost lane sees blank neighbours.
  for (genvar c = 0; c < MAX_SRC_WIDTH; c++) begin : g_lane
    logic up_b, cur_b, dn_b;
    if (c + 1 < MAX_SRC_WIDTH) begin : g_nb
      assign up_b  = up_row[c+1];
      assign cur_b = cur_row[c+1];
      assign dn_b  = dn_row[c+1];
    end else begin : g_edge
      assign up_b  = 1'b0;
      assign cur_b = 1'b0;
      assign dn_b  = 1'b0;
    end

    gus_lane u_lane (
      .up_a   (up_row[c]),
      .up_b   (up_b),
      .cur_a  (cur_row[c]),
      .cur_b  (cur_b),
      .dn_a   (dn_row[c]),
      .dn_b   (dn_b),
      .phase  (phase),
      .nibble (nibbles[c])
    );
  end

  gus_merge #(
    .MAX_SRC_WIDTH (MAX_SRC_WIDTH)
  ) u_merge (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .nibbles       (nibbles),
    .row_ready     (row_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_row_index (out_row_index),
    .out_pixels    (out_pixels),
    .last_row      (last_row)
  );

endmodule

>>> src/gus_seq.sv
// Glyph store and output row sequencer: normalises the glyph on transfer,
// then walks source rows through a shift line. Depends on gus_pkg.
module gus_seq import gus_pkg::*; #(
  parameter int MAX_SRC_WIDTH  = DEF_MAX_SRC_WIDTH,
  parameter int MAX_SRC_HEIGHT = DEF_MAX_SRC_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [3:0]                    glyph_width,
  input  logic [2:0]                    glyph_height,
  input  logic [NROW-1:0][SRC_W-1:0]    rows_in,
  input  logic                          row_ready,
  output row_ctrl_t                     ctrl,
  output logic                          phase,
  output logic [MAX_SRC_WIDTH-1:0]      up_row,
  output logic [MAX_SRC_WIDTH-1:0]      cur_row,
  output logic [MAX_SRC_WIDTH-1:0]      dn_row
);

  localparam int EFF_H = (MAX_SRC_HEIGHT < NROW) ? MAX_SRC_HEIGHT : NROW;
  localparam logic [2:0] EFF_H3 = 3'(EFF_H);
  localparam logic [4:0] MAXW5  = 5'(MAX_SRC_WIDTH);
  localparam logic [4:0] SRCW5  = 5'(SRC_W);

  logic                     busy;
  logic [IDX_W-1:0]         k;
  logic [IDX_W-1:0]         last_k;
  logic [MAX_SRC_WIDTH-1:0] g [EFF_H];
  logic [MAX_SRC_WIDTH-1:0] prev;

  logic                     adv, is_last, take;
  logic [2:0]               h_eff;
  logic [4:0]               w_eff;
  logic [MAX_SRC_WIDTH-1:0] norm [EFF_H];

  assign adv      = busy && row_ready;
  assign is_last  = (k == last_k);
  assign in_ready = !busy || (adv && is_last);
  assign take     = in_valid && in_ready;

  assign h_eff = (glyph_height > EFF_H3) ? EFF_H3 : glyph_height;
  assign w_eff = ({1'b0, glyph_width} > MAXW5) ? MAXW5 : {1'b0, glyph_width};

  // Reverse columns so column c sits at bit c; blank rows and columns past the glyph.
  always_comb begin
    logic [4:0] pos;
    for (int r = 0; r < EFF_H; r++) begin
      for (int c = 0; c < MAX_SRC_WIDTH; c++) begin
        pos = w_eff - 5'd1 - 5'(c);
        if ((5'(c) < w_eff) && (3'(r) < h_eff) && (pos < SRCW5)) begin
          norm[r][c] = rows_in[r][pos[SRC_IW-1:0]];
        end else begin
          norm[r][c] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      k    <= '0;
    end else if (take) begin
      busy <= (h_eff != 3'd0);
      k    <= '0;
    end else if (adv) begin
      if (is_last) begin
        busy <= 1'b0;
      end else begin
        k <= k + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      last_k <= {h_eff, 1'b0} - 4'd1;
      prev   <= '0;
      for (int r = 0; r < EFF_H; r++) begin
        g[r] <= norm[r];
      end
    end else if (adv && !is_last && k[0]) begin
      prev <= g[0];
      for (int r = 0; r < EFF_H - 1; r++) begin
        g[r] <= g[r+1];
      end
      g[EFF_H-1] <= '0;
    end
  end

  assign ctrl.valid = busy;
  assign ctrl.index = k;
  assign ctrl.last  = is_last;
  assign phase      = k[0];
  assign up_row     = prev;
  assign cur_row    = g[0];
  assign dn_row     = g[1];

endmodule

>>> src/gus_lane.sv
// One column lane: 2x block plus the diagonal patches of the windows above
// and below the current source row. Depends on gus_pkg.
module gus_lane import gus_pkg::*; (
  input  logic       up_a,
  input  logic       up_b,
  input  logic       cur_a,
  input  logic       cur_b,
  input  logic       dn_a,
  input  logic       dn_b,
  input  logic       phase,
  output logic [3:0] nibble
);

  logic anti_hi, diag_hi, anti_lo, diag_lo;

  // window (up, cur) contributes its lower patch rows, (cur, dn) its upper ones
  assign anti_hi = !up_a && up_b && cur_a && !cur_b;
  assign diag_hi = up_a && !up_b && !cur_a && cur_b;
  assign anti_lo = !cur_a && cur_b && dn_a && !dn_b;
  assign diag_lo = cur_a && !cur_b && !dn_a && dn_b;

  assign nibble = (anti_hi ? anti_patch({1'b1, phase}) : 4'h0)
                | (diag_hi ? diag_patch({1'b1, phase}) : 4'h0)
                | (anti_lo ? anti_patch({1'b0, phase}) : 4'h0)
                | (diag_lo ? diag_patch({1'b0, phase}) : 4'h0)
                | {2'b00, {2{cur_a}}};

endmodule

>>> src/gus_merge.sv
// Merge stage: ORs the lane nibbles into one output row and holds it in
// the output register. Depends on gus_pkg.
module gus_merge import gus_pkg::*; #(
  parameter int MAX_SRC_WIDTH = DEF_MAX_SRC_WIDTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  row_ctrl_t               ctrl,
  input  logic [3:0]              nibbles [MAX_SRC_WIDTH],
  output logic                    row_ready,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [IDX_W-1:0]        out_row_index,
  output logic [OUT_W-1:0]        out_pixels,
  output logic                    last_row
);

  localparam int WIDE_W = (2 * MAX_SRC_WIDTH + 2 > OUT_W) ? 2 * MAX_SRC_WIDTH + 2 : OUT_W;

  logic [WIDE_W-1:0] wide;
  logic              load;

  always_comb begin
    wide = '0;
    for (int c = 0; c < MAX_SRC_WIDTH; c++) begin
      wide = wide | (WIDE_W'(nibbles[c]) << (2 * c));
    end
  end

  assign row_ready = !out_valid || out_ready;
  assign load      = ctrl.valid && row_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (row_ready) begin
      out_valid <= ctrl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_row_index <= ctrl.index;
      out_pixels    <= wide[OUT_W-1:0];
      last_row      <= ctrl.last;
    end
  end

endmodule

>>> src/gus_checker.sv
// Port-level checks for the glyph upscaler, bound to the top level.
// Depends on gus_pkg and glyph_upscale_2x_smoothing.
module gus_checker import gus_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_ready,
  input logic [IDX_W-1:0] out_row_index,
  input logic [OUT_W-1:0] out_pixels,
  input logic             last_row
);

  localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(2 * NROW - 1);

  logic [IDX_W-1:0] exp_idx;

  // expected index of the next output row
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_idx <= '0;
    end else if (out_valid && out_ready) begin
      exp_idx <= last_row ? '0 : out_row_index + 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_pixels)
      && $stable(out_row_index) && $stable(last_row))
    else $error("output row changed while stalled");

  a_row_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_row_index == exp_idx)
    else $error("output rows out of order");

  a_last_odd: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_row |-> out_row_index[0])
    else $error("glyph ended on an odd number of rows");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_row_index <= MAX_IDX)
    else $error("output row index beyond glyph height");

endmodule

bind glyph_upscale_2x_smoothing gus_checker u_gus_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_row_index (out_row_index),
  .out_pixels    (out_pixels),
  .last_row      (last_row)
);
